// ===== sv/polar_channel_transform_log2_top_assert.svh =====
// Assertion macros shared by the polar channel transform RTL.
`ifndef POLAR_CHANNEL_TRANSFORM_LOG2_TOP_ASSERT_SVH
`define POLAR_CHANNEL_TRANSFORM_LOG2_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pct assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pct assertion failed");

`endif

// ===== sv/pct_pkg.sv =====
// Package with constants, codes and table helpers of the polar channel transform.
`default_nettype none
package pct_pkg;

  localparam int SAMPLE_WIDTH     = 20;
  localparam int FRAC_BITS        = 10;
  localparam int CORR_TABLE_DEPTH = 256;
  localparam int STEP_BITS        = 4;
  localparam int Q_BITS           = 30;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register index as seen on paddr bit 2.
  localparam logic REG_TRANSFORM_MODE = 1'b0;

  // Transform mode codes.
  localparam logic MODE_MINUS = 1'b0;
  localparam logic MODE_PLUS  = 1'b1;

  // Integer square root, bit by bit, as used for the 2^-(1/2^k) roots.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int n = 0; n < 32; n++) begin
      if (bitv > v) begin
        bitv = bitv >> 2;
      end
    end
    for (int n = 0; n < 32; n++) begin
      if (bitv != 64'd0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // Correction entry log2(1 + 2^-(idx/16)) with frac fraction bits. Only
  // evaluated at elaboration to build the constant table.
  function automatic logic [31:0] corr_value(input int idx, input int frac);
    logic [63:0] roots [STEP_BITS];
    logic [63:0] r;
    logic [63:0] y;
    logic [63:0] v;
    logic [63:0] acc;
    int          ip;
    int          f;
    r = 64'd1 << (Q_BITS - 1);
    for (int k = 0; k < STEP_BITS; k++) begin
      r        = isqrt64(r << Q_BITS);
      roots[k] = r;
    end
    y  = 64'd1 << Q_BITS;
    ip = idx >> STEP_BITS;
    f  = idx & ((1 << STEP_BITS) - 1);
    for (int k = 0; k < STEP_BITS; k++) begin
      if (((f >> (STEP_BITS - 1 - k)) & 1) != 0) begin
        y = (y * roots[k]) >> Q_BITS;
      end
    end
    y   = (ip > Q_BITS) ? 64'd0 : (y >> ip);
    v   = (64'd1 << Q_BITS) + y;
    acc = 64'd0;
    if (v >= (64'd2 << Q_BITS)) begin
      acc = 64'd1;
      v   = v >> 1;
    end
    for (int b = 0; b < frac + 1; b++) begin
      v   = (v * v) >> Q_BITS;
      acc = acc << 1;
      if (v >= (64'd2 << Q_BITS)) begin
        acc = acc | 64'd1;
        v   = v >> 1;
      end
    end
    acc = (acc + 64'd1) >> 1;
    return acc[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/pct_corr_rom.sv =====
// Constant max-star correction table, built at elaboration and read combinationally.
`default_nettype none
module pct_corr_rom #(
  parameter int FRAC_BITS        = pct_pkg::FRAC_BITS,
  parameter int CORR_TABLE_DEPTH = pct_pkg::CORR_TABLE_DEPTH
) (
  input  wire logic [$clog2(CORR_TABLE_DEPTH)-1:0] idx_i,
  output logic      [FRAC_BITS:0]                  val_o
);

  logic [FRAC_BITS:0] tab [CORR_TABLE_DEPTH];

  for (genvar g = 0; g < CORR_TABLE_DEPTH; g++) begin : g_entry
    localparam logic [31:0] EntryVal = pct_pkg::corr_value(g, FRAC_BITS);
    assign tab[g] = EntryVal[FRAC_BITS:0];
  end

  // Indexes past a non power of two depth are masked by the caller.
  assign val_o = tab[idx_i];

endmodule
`default_nettype wire

// ===== sv/polar_channel_transform_log2_top.sv =====
// Top level of the base-2 log domain polar channel transform with APB mode register.
`default_nettype none
// The block combines two binary-input channel columns into the transformed
// log2 probabilities of a polar code stage. Each request carries the bit 0
// and bit 1 log2 probabilities of a first and a second channel. In minus mode
// (transform_mode = 0) it returns one result holding -1 plus the base-2
// max-star of the cross sums, with the correction taken from a constant table
// indexed by the difference in steps of 1/16. In plus mode (transform_mode = 1)
// it returns two results, first for first bit 0 then for first bit 1
// (upper_half set), each holding plain sums minus 1. last_of_item marks the
// final result of a request. All values are signed fixed point and saturate.
// The datapath is a four stage pipeline: input register, cross sums, compare
// and table index, correction add with saturation into the output register.
// In minus mode a request is accepted every cycle while the output does not
// stall; in plus mode the output port carries one result per cycle when not
// stalled and the output register holds the item for both of its results, so
// it takes a new item only after the second. When every stage is full,
// a stall at the output reaches the request side in the same cycle; empty
// stages still close up behind a held result, so nothing is lost or repeated.
// transform_mode may only be written while no request is in flight.
module polar_channel_transform_log2_top #(
  parameter int SAMPLE_WIDTH     = pct_pkg::SAMPLE_WIDTH,
  parameter int FRAC_BITS        = pct_pkg::FRAC_BITS,
  parameter int CORR_TABLE_DEPTH = pct_pkg::CORR_TABLE_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // APB configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pct_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [pct_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [pct_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  // Request channel.
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    first_chan_p0_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    first_chan_p1_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    second_chan_p0_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    second_chan_p1_i,
  // Result channel.
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]         result_p0_o,
  output logic signed [SAMPLE_WIDTH-1:0]         result_p1_o,
  output logic                                   upper_half_o,
  output logic                                   last_of_item_o
);

`include "polar_channel_transform_log2_top_assert.svh"

  localparam int SW     = SAMPLE_WIDTH;
  localparam int SUM_W  = SW + 1;          // sum of two samples
  localparam int DIFF_W = SW + 2;          // difference of two sums
  localparam int ACC_W  = SW + 3;          // sum plus correction minus one
  localparam int IDX_W  = $clog2(CORR_TABLE_DEPTH);
  localparam int IDX_SHIFT = FRAC_BITS - pct_pkg::STEP_BITS;

  localparam logic signed [ACC_W-1:0] SatHi = {4'b0000, {(SW - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SatLo = {4'b1111, {(SW - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] OneFx = ACC_W'(1) << FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------------
  logic mode_q;
  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == pct_pkg::REG_TRANSFORM_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= pct_pkg::MODE_MINUS;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pct_pkg::REG_TRANSFORM_MODE)
                  ? {{(pct_pkg::APB_DATA_W - 1){1'b0}}, mode_q}
                  : '0;

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves when the one after it is free.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, o_valid_q, beat_q;
  logic o_mode_q;
  logic o_last, o_free, s3_free, s2_free, s1_free;

  // A minus item has one result; a plus item is done after its second beat.
  assign o_last  = (o_mode_q == pct_pkg::MODE_MINUS) || beat_q;
  assign o_free  = !o_valid_q || (!out_stall_i && o_last);
  assign s3_free = !s3_valid_q || o_free;
  assign s2_free = !s2_valid_q || s3_free;
  assign s1_free = !s1_valid_q || s2_free;

  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
      beat_q     <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_free) begin
        s3_valid_q <= s2_valid_q;
      end
      if (o_free) begin
        o_valid_q <= s3_valid_q;
      end
      // The first plus beat taken moves the output to the upper half.
      if (o_valid_q && !out_stall_i && !o_last) begin
        beat_q <= 1'b1;
      end else if (o_free) begin
        beat_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register. The mode is sampled with the request.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] s1_a0_q, s1_a1_q, s1_b0_q, s1_b1_q;
  logic                 s1_mode_q;

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_a0_q   <= first_chan_p0_i;
      s1_a1_q   <= first_chan_p1_i;
      s1_b0_q   <= second_chan_p0_i;
      s1_b1_q   <= second_chan_p1_i;
      s1_mode_q <= mode_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the four cross sums at full width.
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] s2_s00_q, s2_s11_q, s2_s10_q, s2_s01_q;
  logic                    s2_mode_q;

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) begin
      s2_s00_q  <= SUM_W'(s1_a0_q) + SUM_W'(s1_b0_q);
      s2_s11_q  <= SUM_W'(s1_a1_q) + SUM_W'(s1_b1_q);
      s2_s10_q  <= SUM_W'(s1_a1_q) + SUM_W'(s1_b0_q);
      s2_s01_q  <= SUM_W'(s1_a0_q) + SUM_W'(s1_b1_q);
      s2_mode_q <= s1_mode_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: maximum and table index of each max-star pair. Plus mode passes
  // the sums straight through.
  // ---------------------------------------------------------------------------
  logic                     gt0, gt1;
  logic signed [DIFF_W-1:0] dif0, dif1;
  logic        [DIFF_W-1:0] mag0, mag1, idxf0, idxf1;
  logic signed [SUM_W-1:0]  mx0, mx1;

  assign gt0   = s2_s00_q > s2_s11_q;
  assign gt1   = s2_s10_q > s2_s01_q;
  assign mx0   = gt0 ? s2_s00_q : s2_s11_q;
  assign mx1   = gt1 ? s2_s10_q : s2_s01_q;
  assign dif0  = DIFF_W'(s2_s00_q) - DIFF_W'(s2_s11_q);
  assign dif1  = DIFF_W'(s2_s10_q) - DIFF_W'(s2_s01_q);
  assign mag0  = gt0 ? dif0 : -dif0;
  assign mag1  = gt1 ? dif1 : -dif1;
  assign idxf0 = mag0 >> IDX_SHIFT;
  assign idxf1 = mag1 >> IDX_SHIFT;

  logic signed [SUM_W-1:0] s3_x0_q, s3_x1_q, s3_x2_q, s3_x3_q;
  logic                    s3_hit0_q, s3_hit1_q, s3_mode_q;
  logic [IDX_W-1:0]        s3_idx0_q, s3_idx1_q;

  always_ff @(posedge clk_i) begin
    if (s3_free && s2_valid_q) begin
      s3_mode_q <= s2_mode_q;
      s3_x2_q   <= s2_s10_q;
      s3_x3_q   <= s2_s01_q;
      if (s2_mode_q == pct_pkg::MODE_PLUS) begin
        s3_x0_q <= s2_s00_q;
        s3_x1_q <= s2_s11_q;
      end else begin
        s3_x0_q <= mx0;
        s3_x1_q <= mx1;
      end
      // Past the end of the table the correction is zero.
      s3_hit0_q <= (s2_mode_q == pct_pkg::MODE_MINUS)
                   && (idxf0 < DIFF_W'(CORR_TABLE_DEPTH));
      s3_hit1_q <= (s2_mode_q == pct_pkg::MODE_MINUS)
                   && (idxf1 < DIFF_W'(CORR_TABLE_DEPTH));
      s3_idx0_q <= idxf0[IDX_W-1:0];
      s3_idx1_q <= idxf1[IDX_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: correction, minus one and saturation into the output register.
  // ---------------------------------------------------------------------------
  logic [FRAC_BITS:0] corr0, corr1;

  pct_corr_rom #(
    .FRAC_BITS        (FRAC_BITS),
    .CORR_TABLE_DEPTH (CORR_TABLE_DEPTH)
  ) u_rom0 (
    .idx_i (s3_idx0_q),
    .val_o (corr0)
  );

  pct_corr_rom #(
    .FRAC_BITS        (FRAC_BITS),
    .CORR_TABLE_DEPTH (CORR_TABLE_DEPTH)
  ) u_rom1 (
    .idx_i (s3_idx1_q),
    .val_o (corr1)
  );

  function automatic logic signed [SW-1:0] sat_fn(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SatHi) begin
      c = SatHi;
    end else if (v < SatLo) begin
      c = SatLo;
    end
    return c[SW-1:0];
  endfunction

  logic signed [ACC_W-1:0] y0, y1, y2, y3;

  assign y0 = ACC_W'(s3_x0_q) + (s3_hit0_q ? ACC_W'(corr0) : ACC_W'(0)) - OneFx;
  assign y1 = ACC_W'(s3_x1_q) + (s3_hit1_q ? ACC_W'(corr1) : ACC_W'(0)) - OneFx;
  assign y2 = ACC_W'(s3_x2_q) - OneFx;
  assign y3 = ACC_W'(s3_x3_q) - OneFx;

  logic signed [SW-1:0] o_r0_q, o_r1_q, o_r2_q, o_r3_q;

  always_ff @(posedge clk_i) begin
    if (o_free && s3_valid_q) begin
      o_r0_q   <= sat_fn(y0);
      o_r1_q   <= sat_fn(y1);
      o_r2_q   <= sat_fn(y2);
      o_r3_q   <= sat_fn(y3);
      o_mode_q <= s3_mode_q;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign result_p0_o    = beat_q ? o_r2_q : o_r0_q;
  assign result_p1_o    = beat_q ? o_r3_q : o_r1_q;
  assign upper_half_o   = beat_q;
  assign last_of_item_o = o_last;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `PCT_ASSERT_SAME(a_beat_only_when_full, clk_i, rst_ni, beat_q, o_valid_q)
  `PCT_ASSERT_SAME(a_upper_only_plus, clk_i, rst_ni, o_valid_q && beat_q,
                   o_mode_q == pct_pkg::MODE_PLUS)
  `PCT_ASSERT_NEXT(a_plus_second_beat, clk_i, rst_ni,
                   o_valid_q && !out_stall_i && !o_last,
                   o_valid_q && beat_q)
  `PCT_ASSERT_SAME(a_empty_front_no_stall, clk_i, rst_ni, !s1_valid_q, !in_stall_o)

endmodule
`default_nettype wire
